@@ src/ptts_pkg.sv @@
// Package for the periodic task tick scheduler: sizing constants, command
// codes and the job record passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package ptts_pkg;

  localparam int NUM_TASKS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int OUT_IDX_W   = 3;
  localparam int CD_W        = 16;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic             is_tick;
    logic [IDX_W-1:0] idx;
    logic [CD_W-1:0]  period;
    logic [CD_W-1:0]  delay;
  } job_t;

endpackage

@@ src/ptts_front.sv @@
// Front end: takes commands, drops creates that would be ignored and
// forwards ticks and valid creates as jobs. Depends on ptts_pkg.
`timescale 1ns / 1ps

module ptts_front
  import ptts_pkg::*;
(
  input  logic        start,
  input  logic        q_full,
  input  logic        in_cmd,
  input  logic [7:0]  in_slot,
  input  logic [15:0] in_period,
  input  logic [15:0] in_first_delay,
  input  logic        in_handler_given,
  output logic        busy,
  output logic        push,
  output job_t        push_job
);

  logic accept;
  logic create_ok;

  assign busy      = q_full;
  assign accept    = start && !q_full;
  // slot range check against the table size
  assign create_ok = (in_slot < 8'(NUM_TASKS)) && in_handler_given;
  assign push      = accept && ((in_cmd == CMD_TICK) || create_ok);

  always_comb begin
    push_job.is_tick = (in_cmd == CMD_TICK);
    push_job.idx     = IDX_W'(in_slot);
    push_job.period  = in_period;
    push_job.delay   = in_first_delay;
  end

endmodule

@@ src/ptts_queue.sv @@
// Two-entry job queue between front and back end.
// Depends on ptts_pkg.
`timescale 1ns / 1ps

module ptts_queue
  import ptts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic q_valid,
  output job_t q_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ src/ptts_back.sv @@
// Back end: slot table and the per-tick scan, one slot per cycle, with a
// one-deep hold of the latest firing so the last result can be flagged.
// Depends on ptts_pkg.
`timescale 1ns / 1ps

module ptts_back
  import ptts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  output logic       out_valid,
  output logic [2:0] out_task_index,
  output logic       out_fired,
  output logic       out_last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam int         XIDX_W   = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             pres_r [NUM_TASKS];
  logic [CD_W-1:0]  cd_r   [NUM_TASKS];
  logic [CD_W-1:0]  per_r  [NUM_TASKS];

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic             wpres;
  logic [CD_W-1:0]  wcd;
  logic [CD_W-1:0]  wper;

  logic             rd_pres;
  logic [CD_W-1:0]  rd_cd;
  logic [CD_W-1:0]  rd_per;
  logic             at_zero;
  logic             fire;

  logic             emit;
  logic [IDX_W-1:0] emit_idx;
  logic             emit_fired;
  logic             emit_last;
  logic [XIDX_W-1:0] emit_idx_x;

  logic             out_valid_r;
  logic [2:0]       out_idx_r;
  logic             out_fired_r;
  logic             out_last_r;

  assign rd_pres = pres_r[idx_r];
  assign rd_cd   = cd_r[idx_r];
  assign rd_per  = per_r[idx_r];
  assign at_zero = (rd_cd == '0);
  assign fire    = at_zero && rd_pres && (cnt_r < CNT_W'(MAX_RESULTS));

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pend_idx_nxt = pend_idx_r;
    pend_v_nxt   = pend_v_r;
    cnt_nxt      = cnt_r;
    pop          = 1'b0;
    we           = 1'b0;
    waddr        = idx_r;
    wpres        = rd_pres;
    wcd          = rd_cd;
    wper         = rd_per;
    emit         = 1'b0;
    emit_idx     = pend_idx_r;
    emit_fired   = 1'b1;
    emit_last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_job.is_tick) begin
            state_nxt  = ST_SCAN;
            idx_nxt    = '0;
            pend_v_nxt = 1'b0;
            cnt_nxt    = '0;
          end else begin
            we    = 1'b1;
            waddr = q_job.idx;
            wpres = 1'b1;
            wcd   = q_job.delay;
            wper  = q_job.period;
          end
        end
      end
      ST_SCAN: begin
        we  = 1'b1;
        // reload at zero (wraps when period is zero), else count down
        wcd = at_zero ? (rd_per - 1'b1) : (rd_cd - 1'b1);
        if (fire) begin
          emit         = pend_v_r;
          pend_idx_nxt = idx_r;
          pend_v_nxt   = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end
        if (idx_r == IDX_W'(NUM_TASKS - 1)) begin
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        // held firing goes out as last; a quiet tick reports index 0
        emit       = 1'b1;
        emit_idx   = pend_v_r ? pend_idx_r : '0;
        emit_fired = pend_v_r;
        emit_last  = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign emit_idx_x = XIDX_W'(emit_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    out_idx_r  <= emit_idx_x[2:0];
    out_fired_r <= emit_fired;
    out_last_r <= emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        pres_r[i] <= 1'b0;
        cd_r[i]   <= '0;
        per_r[i]  <= '0;
      end
    end else if (we) begin
      pres_r[waddr] <= wpres;
      cd_r[waddr]   <= wcd;
      per_r[waddr]  <= wper;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_task_index = out_idx_r;
  assign out_fired      = out_fired_r;
  assign out_last       = out_last_r;

endmodule

@@ src/periodic_task_tick_scheduler.sv @@
// Top level of the periodic task tick scheduler: front end, job queue and
// back end. Depends on ptts_pkg, ptts_front, ptts_queue and ptts_back.
`timescale 1ns / 1ps

// Usage: a command transfers on a rising edge with start high and busy low.
// A create (in_cmd 0) writes one task slot and produces no result; it is
// dropped when the slot is out of range or no handler is given. A tick
// (in_cmd 1) walks the slot table one slot per cycle and then flushes
// the held firing from a final state; a create is a single write to the
// slot table. Results come out as one-cycle strobes on out_valid,
// lowest slot first, with out_last on the final one; a tick with no firing
// gives a single result with out_fired low. The receiver cannot stall, so
// results are never held back. A two-entry queue sits between the command
// front end and the scan engine: busy rises only when both entries wait.
module periodic_task_tick_scheduler
  import ptts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [7:0]  in_slot,
  input  logic [15:0] in_period,
  input  logic [15:0] in_first_delay,
  input  logic        in_handler_given,
  output logic        out_valid,
  output logic [2:0]  out_task_index,
  output logic        out_fired,
  output logic        out_last
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic pop;

  // command decode and filtering of ignored creates
  ptts_front u_front (
    .start            (start),
    .q_full           (q_full),
    .in_cmd           (in_cmd),
    .in_slot          (in_slot),
    .in_period        (in_period),
    .in_first_delay   (in_first_delay),
    .in_handler_given (in_handler_given),
    .busy             (busy),
    .push             (push),
    .push_job         (push_job)
  );

  // decouples command transfers from the tick scan
  ptts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // slot table, scan and result generation
  ptts_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_task_index (out_task_index),
    .out_fired      (out_fired),
    .out_last       (out_last)
  );

  // a quiet result is always the only, hence last, result of its tick
  a_quiet_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fired) |-> out_last)
    else $error("quiet result without last");

  // a quiet result reports slot zero
  a_quiet_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fired) |-> (out_task_index == 3'd0))
    else $error("quiet result with nonzero index");

  // the next tick cannot report in the cycle right after a last result
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result directly after last");

  // queue only pops what it holds
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

@@ bench/periodic_task_tick_scheduler_tb.sv @@
// Self-checking bench for periodic_task_tick_scheduler: directed and random
// create/tick traffic checked against a cycle-free model of the slot table.
// Depends on ptts_pkg and the periodic_task_tick_scheduler RTL.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_tb;
  import ptts_pkg::*;

  // Watchdog. A tick costs its back-end scan plus queueing and at most one
  // idle burst, so 500 items need far less than this.
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;   // two queued ticks plus one in the scan
  localparam int MAX_PRINTS = 20;

  // One expected result of a tick.
  typedef struct packed {
    logic [2:0] task_index;
    logic       fired;
    logic       last;
  } fire_rec_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [7:0]  in_slot;
  logic [15:0] in_period;
  logic [15:0] in_first_delay;
  logic        in_handler_given;
  logic        out_valid;
  logic [2:0]  out_task_index;
  logic        out_fired;
  logic        out_last;

  // Shadow copy of the slot table.
  logic             slot_live   [NUM_TASKS];
  logic [15:0]      slot_count  [NUM_TASKS];
  logic [15:0]      slot_reload [NUM_TASKS];

  fire_rec_t firing_q[$];   // results still owed by the DUT

  int errors = 0;
  int n_creates = 0;
  int n_taken = 0;
  int n_ticks = 0;
  int n_firings = 0;
  int n_quiet = 0;
  int gap_pct = 0;          // chance of an idle burst between transfers

  periodic_task_tick_scheduler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_slot          (in_slot),
    .in_period        (in_period),
    .in_first_delay   (in_first_delay),
    .in_handler_given (in_handler_given),
    .out_valid        (out_valid),
    .out_task_index   (out_task_index),
    .out_fired        (out_fired),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             firing_q.size());
    $display("** periodic_task_tick_scheduler: FAILED **");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Apply one accepted command to the shadow table and queue what it owes.
  task automatic model_command(logic cmd, logic [7:0] slot, logic [15:0] period,
                               logic [15:0] delay, logic given);
    logic [NUM_TASKS-1:0] hit;
    int n_hit;
    int k;
    fire_rec_t rec;
    hit = '0;
    n_hit = 0;
    k = 0;
    if (cmd == CMD_CREATE) begin
      n_creates++;
      // out-of-range slot or missing handler: the create is dropped
      if (slot < NUM_TASKS && given) begin
        slot_count[slot[IDX_W-1:0]]  = delay;
        slot_reload[slot[IDX_W-1:0]] = period;
        slot_live[slot[IDX_W-1:0]]   = 1'b1;
        n_taken++;
      end
    end else begin
      n_ticks++;
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (slot_count[i] == 16'd0) begin
          if (slot_live[i] && n_hit < MAX_RESULTS) begin
            hit[i] = 1'b1;
            n_hit++;
          end
          // absent slots reload too; period zero wraps to 65535
          slot_count[i] = slot_reload[i] - 16'd1;
        end else begin
          slot_count[i] = slot_count[i] - 16'd1;
        end
      end
      if (n_hit == 0) begin
        rec = '{task_index: 3'd0, fired: 1'b0, last: 1'b1};
        firing_q.push_back(rec);
        n_quiet++;
      end else begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (hit[i]) begin
            k++;
            rec = '{task_index: 3'(i), fired: 1'b1, last: (k == n_hit)};
            firing_q.push_back(rec);
          end
        end
        n_firings += n_hit;
      end
    end
  endtask

  // Monitor: results are checked first, then any command transferred on this
  // edge is modeled. Everything is read at the edge, so only pre-edge values
  // are seen and the order against the DUT's own processes does not matter.
  always @(posedge clk) begin : monitor
    fire_rec_t want;
    if (rst_n && out_valid) begin
      if (firing_q.size() == 0) begin
        report_mismatch("result with nothing expected, task_index", out_task_index, 0);
      end else begin
        want = firing_q.pop_front();
        if (out_task_index !== want.task_index)
          report_mismatch("task_index", out_task_index, want.task_index);
        if (out_fired !== want.fired)
          report_mismatch("fired", out_fired, want.fired);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
    if (rst_n && start && !busy)
      model_command(in_cmd, in_slot, in_period, in_first_delay, in_handler_given);
  end

  // Present one command and hold it until it transfers. Called at a clock
  // edge; returns at the edge where the transfer happened with start still
  // high, so a back-to-back command needs no extra edge.
  task automatic send_item(logic cmd, logic [7:0] slot, logic [15:0] period,
                           logic [15:0] delay, logic given);
    start            <= 1'b1;
    in_cmd           <= cmd;
    in_slot          <= slot;
    in_period        <= period;
    in_first_delay   <= delay;
    in_handler_given <= given;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 99) < gap_pct)
      idle_for($urandom_range(1, 5));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (firing_q.size() != 0) @(posedge clk);
  endtask

  // Mostly short spans so slots fire often; sometimes zero or full range.
  function automatic logic [15:0] pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      return 16'd0;
    if (r < 90)
      return 16'($urandom_range(1, 6));
    return 16'($urandom);
  endfunction

  // Ticks carry junk in the create fields; creates are mostly well formed,
  // with some noise creates that may be dropped.
  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      send_item(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    else if (r < 90)
      send_item(CMD_CREATE, 8'($urandom_range(0, NUM_TASKS - 1)), pick_span(),
                pick_span(), 1'b1);
    else
      send_item(CMD_CREATE, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    maybe_gap();
  endtask

  // Never-created slots sit at zero: they reload without firing.
  task automatic test_quiet_ticks();
    send_item(CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
    send_item(CMD_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
  endtask

  // Out-of-range slots and creates without a handler leave the table alone.
  task automatic test_dropped_creates();
    send_item(CMD_CREATE, 8'(NUM_TASKS), 16'd1, 16'd0, 1'b1);
    send_item(CMD_CREATE, 8'hFF, 16'd1, 16'd0, 1'b1);
    send_item(CMD_CREATE, 8'd3, 16'd1, 16'd0, 1'b0);
    send_item(CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
  endtask

  // Every slot fires on the same tick: the full result burst, twice.
  task automatic test_all_slots_fire();
    for (int i = 0; i < NUM_TASKS; i++)
      send_item(CMD_CREATE, 8'(i), 16'd1, 16'd0, 1'b1);
    send_item(CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
    send_item(CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
  endtask

  // Zero period wraps the reload; the longest delay and period never fire here.
  task automatic test_span_extremes();
    send_item(CMD_CREATE, 8'd0, 16'd0, 16'd0, 1'b1);
    send_item(CMD_CREATE, 8'(NUM_TASKS - 1), 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(CMD_CREATE, 8'd5, 16'd2, 16'd1, 1'b1);
    repeat (3) send_item(CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
  endtask

  task automatic test_random_traffic(int n_items, int pct);
    gap_pct = pct;
    repeat (n_items) send_random();
  endtask

  // Sender holds off until the DUT has paid out everything, then resumes.
  task automatic test_drain_pause();
    wait_drained();
    send_item(CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
  endtask

  initial begin : main
    for (int i = 0; i < NUM_TASKS; i++) begin
      slot_live[i]   = 1'b0;
      slot_count[i]  = 16'd0;
      slot_reload[i] = 16'd0;
    end
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_cmd           <= CMD_CREATE;
    in_slot          <= 8'd0;
    in_period        <= 16'd0;
    in_first_delay   <= 16'd0;
    in_handler_given <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_quiet_ticks();
    test_dropped_creates();
    test_all_slots_fire();
    test_span_extremes();
    test_random_traffic(220, 30);
    test_drain_pause();
    test_random_traffic(80, 0);      // back-to-back stretch
    test_random_traffic(100, 40);
    test_random_traffic(70, 0);      // no idling in the last part

    start <= 1'b0;
    @(posedge clk);
    while (firing_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (firing_q.size() != 0)
      report_mismatch("results never delivered, count", 0, firing_q.size());

    $display("covered %0d creates (%0d taken) and %0d ticks with %0d firings",
             n_creates, n_taken, n_ticks, n_firings);
    $display("and %0d quiet ticks; %0d mismatches", n_quiet, errors);
    if (errors == 0) begin
      $display("** periodic_task_tick_scheduler: PASSED **");
    end else begin
      $display("** periodic_task_tick_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
